// ----- hdl/aalr_pkg.sv -----
// ----------------------------------------------------------------------------
// aalr_pkg
// Shared types and constants of the anti-aliased line rasterizer: word
// layouts of both channels, action codes and coverage constants.
// ----------------------------------------------------------------------------
package aalr_pkg;

    localparam int COORD_BITS     = 10;
    localparam int PIX_BITS       = COORD_BITS + 1;
    localparam int COV_BITS       = 9;
    localparam int FRAC_BITS_DEF  = 16;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // coverage in 256ths
    localparam logic [COV_BITS-1:0] COV_FULL = 9'd256;
    localparam logic [COV_BITS-1:0] COV_HALF = 9'd128;
    localparam logic [COV_BITS-1:0] COV_NONE = 9'd0;

    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } t_in_word;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_x;
        logic [PIX_BITS-1:0] pixel_y;
        logic [COV_BITS-1:0] coverage;
        logic                last_of_line;
    } t_out_word;

endpackage

// ----- hdl/aalr_div.sv -----
// ----------------------------------------------------------------------------
// aalr_div
// Iterative restoring divider for the line gradient: one quotient bit per
// cycle, numerator |d_minor| scaled by 2^FRAC_BITS, where |d_minor| <= d_major.
// ----------------------------------------------------------------------------
module aalr_div #(
    parameter int FRAC_BITS = aalr_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [aalr_pkg::COORD_BITS-1:0] i_num,
    input  logic [aalr_pkg::COORD_BITS-1:0] i_den,
    output logic                          o_done,
    output logic [FRAC_BITS:0]            o_quot
);
    import aalr_pkg::*;

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] r_den;
    logic [FRAC_BITS:0]    r_quot;

    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;

    // first step takes the integer bit without shifting
    always_comb begin
        trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            r_quot <= {r_quot[FRAC_BITS-1:0], ge};
            if (r_cnt == CNT_BITS'(FRAC_BITS)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hdl/antialiased_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu-style anti-aliased line generator for integer endpoints.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_word) takes one word at a
// time. A start word (action 0) gives two endpoints; the block picks the
// major axis, orders the endpoints and divides once for the gradient with
// an iterative divider (one quotient bit a cycle), then emits four endpoint
// pixels. A step word (action 1) emits the two pixels of the next interior
// column; a step with no line in progress produces nothing.
// Output channel (o_out_valid / i_out_stall / o_out_word) carries one pixel
// per word through an output register.
// Sequence: a start word goes from accept through setup, the divider
// steps, the wait that sees the divider finish, finish and four emit
// steps; a zero-length line skips the divider. A step word goes from
// accept to its two emit steps. The input stalls while a word is being
// processed.
// An output stall holds the pending pixel and freezes the emit sequence.
// Reset clears the sequencer, the output valid and the line state.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer #(
    parameter int FRAC_BITS = aalr_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aalr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aalr_pkg::t_out_word o_out_word
);
    import aalr_pkg::*;

    localparam int ICPT_BITS = COORD_BITS + FRAC_BITS;
    localparam int SLP_BITS  = FRAC_BITS + 2;
    localparam logic signed [SLP_BITS-1:0] SLOPE_ONE = {2'b01, {FRAC_BITS{1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SETUP  = 5'b00010,
        S_DIV    = 5'b00100,
        S_FINISH = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state                r_state;
    t_in_word              r_in;
    logic                  r_is_start;
    logic [1:0]            r_emit_idx;

    // ordered endpoints in major/minor space
    logic [COORD_BITS-1:0] r_a1, r_b1, r_a2, r_b2;
    logic [COORD_BITS-1:0] r_dmaj;
    logic                  r_neg;

    // line state
    logic                  r_line_active;
    logic                  r_steep_line;
    logic [COORD_BITS-1:0] r_current_column;
    logic [COORD_BITS-1:0] r_final_column;
    logic [ICPT_BITS-1:0]  r_row_intercept;
    logic signed [SLP_BITS-1:0] r_slope;

    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  in_accept;
    logic                  out_free;
    logic                  emit_fire;
    logic                  div_start;
    logic                  div_done;
    logic [FRAC_BITS:0]    div_quot;

    // setup signals
    logic [COORD_BITS-1:0] adx, ady;
    logic                  steep;
    logic [COORD_BITS-1:0] sa1, sb1, sa2, sb2;
    logic                  swap_ends;
    logic [COORD_BITS-1:0] oa1, ob1, oa2, ob2;
    logic [COORD_BITS-1:0] dmin_mag;

    // finish signals
    logic signed [SLP_BITS-1:0] slope_val;
    logic [ICPT_BITS-1:0]  slope_ext;
    logic [ICPT_BITS-1:0]  cur_slope_ext;

    // emit signals
    logic [COORD_BITS-1:0] next_column;
    logic                  step_last;
    logic [COORD_BITS-1:0] emit_major;
    logic [COORD_BITS-1:0] emit_minor_base;
    logic [PIX_BITS-1:0]   emit_minor;
    logic [COV_BITS-1:0]   cov_hi;
    t_out_word             emit_word;
    logic                  emit_final;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit_fire  = (r_state == S_EMIT) && out_free;
    assign div_start  = (r_state == S_SETUP) && (oa2 != oa1);

    always_comb begin
        adx = (r_in.end_x >= r_in.start_x) ? r_in.end_x - r_in.start_x
                                           : r_in.start_x - r_in.end_x;
        ady = (r_in.end_y >= r_in.start_y) ? r_in.end_y - r_in.start_y
                                           : r_in.start_y - r_in.end_y;
        steep = (adx < ady);
        sa1 = steep ? r_in.start_y : r_in.start_x;
        sb1 = steep ? r_in.start_x : r_in.start_y;
        sa2 = steep ? r_in.end_y   : r_in.end_x;
        sb2 = steep ? r_in.end_x   : r_in.end_y;
        swap_ends = (sa2 < sa1);
        oa1 = swap_ends ? sa2 : sa1;
        ob1 = swap_ends ? sb2 : sb1;
        oa2 = swap_ends ? sa1 : sa2;
        ob2 = swap_ends ? sb1 : sb2;
        dmin_mag = (ob2 >= ob1) ? ob2 - ob1 : ob1 - ob2;
    end

    aalr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (dmin_mag),
        .i_den   (oa2 - oa1),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        if (r_dmaj == '0) begin
            slope_val = '0;
        end else if (r_neg) begin
            slope_val = -$signed({1'b0, div_quot});
        end else begin
            slope_val = $signed({1'b0, div_quot});
        end
        slope_ext     = {{(ICPT_BITS-SLP_BITS){slope_val[SLP_BITS-1]}}, slope_val};
        cur_slope_ext = {{(ICPT_BITS-SLP_BITS){r_slope[SLP_BITS-1]}}, r_slope};
    end

    // word builder for the emit sequence
    always_comb begin
        next_column = r_current_column + 1'b1;
        step_last   = (next_column >= r_final_column);
        cov_hi      = {1'b0, r_row_intercept[FRAC_BITS-1:FRAC_BITS-8]};
        if (r_is_start) begin
            emit_major      = r_emit_idx[1] ? r_a2 : r_a1;
            emit_minor_base = r_emit_idx[1] ? r_b2 : r_b1;
            emit_word.coverage     = r_emit_idx[0] ? COV_NONE : COV_HALF;
            emit_word.last_of_line = (r_emit_idx == 2'd3) && !r_line_active;
            emit_final             = (r_emit_idx == 2'd3);
        end else begin
            emit_major      = r_current_column;
            emit_minor_base = r_row_intercept[ICPT_BITS-1:FRAC_BITS];
            emit_word.coverage     = r_emit_idx[0] ? cov_hi : COV_FULL - cov_hi;
            emit_word.last_of_line = r_emit_idx[0] && step_last;
            emit_final             = r_emit_idx[0];
        end
        // neighbor pixel sits one step along the minor axis
        emit_minor = {1'b0, emit_minor_base} + PIX_BITS'(r_emit_idx[0]);
        if (r_steep_line) begin
            emit_word.pixel_x = emit_minor;
            emit_word.pixel_y = {1'b0, emit_major};
        end else begin
            emit_word.pixel_x = {1'b0, emit_major};
            emit_word.pixel_y = emit_minor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_is_start       <= 1'b0;
            r_emit_idx       <= '0;
            r_out_valid      <= 1'b0;
            r_line_active    <= 1'b0;
            r_steep_line     <= 1'b0;
            r_current_column <= '0;
            r_final_column   <= '0;
            r_row_intercept  <= '0;
            r_slope          <= '0;
        end else begin
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_in       <= i_in_word;
                        r_emit_idx <= '0;
                        if (i_in_word.action == ACT_START) begin
                            r_is_start <= 1'b1;
                            r_state    <= S_SETUP;
                        end else if (r_line_active) begin
                            r_is_start <= 1'b0;
                            r_state    <= S_EMIT;
                        end
                    end
                end
                S_SETUP: begin
                    r_a1         <= oa1;
                    r_b1         <= ob1;
                    r_a2         <= oa2;
                    r_b2         <= ob2;
                    r_dmaj       <= oa2 - oa1;
                    r_neg        <= (ob2 < ob1);
                    r_steep_line <= steep;
                    r_state      <= (oa2 == oa1) ? S_FINISH : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_slope          <= slope_val;
                    r_row_intercept  <= {r_b1, {FRAC_BITS{1'b0}}} + slope_ext;
                    r_current_column <= r_a1 + 1'b1;
                    r_final_column   <= r_a2;
                    r_line_active    <= (r_dmaj > COORD_BITS'(1));
                    r_state          <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_word  <= emit_word;
                        r_emit_idx  <= r_emit_idx + 1'b1;
                        if (emit_final) begin
                            r_state <= S_IDLE;
                            if (!r_is_start) begin
                                r_current_column <= next_column;
                                r_row_intercept  <= r_row_intercept + cur_slope_ext;
                                if (step_last) begin
                                    r_line_active <= 1'b0;
                                end
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // block goes busy right after taking a word that has work to do
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_in_word.action == ACT_START || r_line_active) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a step only emits two words
    a_step_two_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && !r_is_start |-> (r_emit_idx == 2'd0 || r_emit_idx == 2'd1))
        else $error("step emit index out of range");

    // gradient magnitude never exceeds one
    a_slope_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slope <= SLOPE_ONE) && (r_slope >= -SLOPE_ONE))
        else $error("slope out of range");

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

endmodule
